// File: hw/rtl/pwbt_pkg.sv
package pwbt_pkg;

    // Default transmit queue depth
    localparam int TX_DEPTH_DEF = 16;

    // Input command codes
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_EDGE = 2'd1;
    localparam logic [1:0] CMD_PUSH = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_SHORT_MIN   = 3'd0;
    localparam logic [2:0] REG_SPLIT_POINT = 3'd1;
    localparam logic [2:0] REG_LONG_MAX    = 3'd2;
    localparam logic [2:0] REG_RX_TIMEOUT  = 3'd3;
    localparam logic [2:0] REG_SKIP_BYTES  = 3'd4;
    localparam logic [2:0] REG_RX_ENABLE   = 3'd5;
    localparam logic [2:0] REG_TX_ENABLE   = 3'd6;

    // Configuration reset values
    localparam logic [15:0] SHORT_MIN_RST   = 16'd40;
    localparam logic [15:0] SPLIT_POINT_RST = 16'd90;
    localparam logic [15:0] LONG_MAX_RST    = 16'd200;
    localparam logic [7:0]  RX_TIMEOUT_RST  = 8'd8;
    localparam logic [1:0]  SKIP_BYTES_RST  = 2'd3;

    // Frame constants
    localparam logic [7:0] PRE_BYTE      = 8'hff;
    localparam logic [7:0] PRE_LAST_BYTE = 8'h7f;
    localparam logic [7:0] RX_START_BITS = 8'h80;
    localparam logic [3:0] BYTE_BITS     = 4'd8;
    localparam logic [1:0] PRE_LAST_STEP = 2'd2;
    localparam logic [1:0] PRE_DONE      = 2'd3;
    localparam logic [7:0] IDLE_MAX      = 8'd255;

    // Receiver configuration
    typedef struct packed {
        logic [15:0] short_min;
        logic [15:0] split_point;
        logic [15:0] long_max;
        logic [7:0]  timeout;
        logic [1:0]  skip;
        logic        enable;
    } rx_cfg_t;

    // Receiver event for one item
    typedef struct packed {
        logic        tick;
        logic        edge_ev;
        logic        rising;
        logic [15:0] interval;
    } rx_ctl_t;

    // Receiver results
    typedef struct packed {
        logic       active_cur;
        logic       active_nxt;
        logic       byte_valid;
        logic [7:0] byte_data;
    } rx_res_t;

    // Transmitter event and queue status
    typedef struct packed {
        logic       tick;
        logic       q_empty;
        logic [7:0] head;
    } tx_ctl_t;

    // Transmitter line state
    typedef struct packed {
        logic level_cur;
        logic drive_cur;
        logic level_nxt;
        logic drive_nxt;
    } tx_res_t;

endpackage

// File: hw/rtl/pwbt_tx_queue.sv
module pwbt_tx_queue #(
    parameter int DEPTH = pwbt_pkg::TX_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic [7:0] push_data,
    input  logic       pop,
    output logic       empty,
    output logic       full,
    output logic [7:0] head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [7:0]    mem [DEPTH];
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    head_reg;

    // Advance pointers with wrap at the queue depth
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_ADDR) ? '0 : rd_ptr_reg + 1'b1;
            count_next  = count_reg - 1'b1;
        end
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_ADDR) ? '0 : wr_ptr_reg + 1'b1;
            count_next  = count_reg + 1'b1;
        end
    end

    // Hold pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write storage; register the head read with forwarding of a same-cycle write
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
        if (push && (wr_ptr_reg == rd_ptr_next))
        begin
            head_reg <= push_data;
        end
        else
        begin
            head_reg <= mem[rd_ptr_next];
        end
    end

    assign empty = (count_reg == '0);
    assign full  = (count_reg == FULL_COUNT);
    assign head  = head_reg;

endmodule

// File: hw/rtl/pwbt_tx_ser.sv
module pwbt_tx_ser (
    input  logic              clk,
    input  logic              rst_n,
    input  pwbt_pkg::tx_ctl_t ctl,
    output logic              pop,
    output pwbt_pkg::tx_res_t res
);

    logic [7:0] shift_reg, shift_next;
    logic [3:0] bits_reg, bits_next;
    logic [1:0] phase_reg, phase_next;
    logic [1:0] pre_reg, pre_next;
    logic       active_reg, active_next;
    logic       drive_reg, drive_next;
    logic       level_reg, level_next;

    // Step the bit-quarter sequencer on each allowed tick
    always_comb
    begin
        logic reload;
        reload      = 1'b0;
        shift_next  = shift_reg;
        bits_next   = bits_reg;
        phase_next  = phase_reg;
        pre_next    = pre_reg;
        active_next = active_reg;
        drive_next  = drive_reg;
        level_next  = level_reg;
        pop         = 1'b0;
        if (ctl.tick)
        begin
            if (pre_reg == '0)
            begin
                level_next = 1'b1;
            end
            if (!active_reg)
            begin
                reload = 1'b1;
            end
            else if (bits_reg != '0)
            begin
                // One: high,high,low,low. Zero: high,low,high,low.
                if (shift_reg[0])
                begin
                    level_next = (phase_reg < 2'd2);
                end
                else
                begin
                    level_next = ~phase_reg[0];
                end
                if (phase_reg == 2'd3)
                begin
                    phase_next = '0;
                    shift_next = shift_reg >> 1;
                    bits_next  = bits_reg - 1'b1;
                    if (bits_reg == 4'd1)
                    begin
                        reload = 1'b1;
                    end
                end
                else
                begin
                    phase_next = phase_reg + 1'b1;
                end
            end
            else
            begin
                // Finished byte with nothing reloaded: go inactive
                active_next = 1'b0;
                if (ctl.q_empty)
                begin
                    drive_next = 1'b0;
                end
            end

            // Load the next preamble or queued byte
            if (reload)
            begin
                if (ctl.q_empty)
                begin
                    pre_next = '0;
                end
                else
                begin
                    if (pre_reg < pwbt_pkg::PRE_DONE)
                    begin
                        shift_next = (pre_reg == pwbt_pkg::PRE_LAST_STEP) ?
                                     pwbt_pkg::PRE_LAST_BYTE : pwbt_pkg::PRE_BYTE;
                        pre_next   = pre_reg + 1'b1;
                    end
                    else
                    begin
                        shift_next = ctl.head;
                        pop        = 1'b1;
                    end
                    bits_next   = pwbt_pkg::BYTE_BITS;
                    active_next = 1'b1;
                    drive_next  = 1'b1;
                end
            end
        end
    end

    // Hold sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg  <= '0;
            bits_reg   <= '0;
            phase_reg  <= '0;
            pre_reg    <= '0;
            active_reg <= 1'b0;
            drive_reg  <= 1'b0;
            level_reg  <= 1'b1;
        end
        else
        begin
            shift_reg  <= shift_next;
            bits_reg   <= bits_next;
            phase_reg  <= phase_next;
            pre_reg    <= pre_next;
            active_reg <= active_next;
            drive_reg  <= drive_next;
            level_reg  <= level_next;
        end
    end

    assign res.level_cur = level_reg;
    assign res.drive_cur = drive_reg;
    assign res.level_nxt = level_next;
    assign res.drive_nxt = drive_next;

endmodule

// File: hw/rtl/pwbt_rx_dec.sv
module pwbt_rx_dec (
    input  logic              clk,
    input  logic              rst_n,
    input  pwbt_pkg::rx_cfg_t cfg,
    input  pwbt_pkg::rx_ctl_t ctl,
    output pwbt_pkg::rx_res_t res
);

    logic       active_reg, active_next;
    logic [7:0] idle_reg, idle_next;
    logic [7:0] shift_reg, shift_next;
    logic [3:0] bitcnt_reg, bitcnt_next;
    logic [1:0] short_reg, short_next;
    logic [1:0] bytes_reg, bytes_next;
    logic       byte_valid;
    logic [7:0] byte_data;

    // Classify edge intervals and assemble bytes; count idle ticks
    always_comb
    begin
        logic is_short;
        logic is_long;
        logic [7:0] idle_inc;
        is_short    = (ctl.interval > cfg.short_min) && (ctl.interval < cfg.split_point);
        is_long     = (ctl.interval > cfg.split_point) && (ctl.interval < cfg.long_max);
        idle_inc    = (idle_reg < pwbt_pkg::IDLE_MAX) ? idle_reg + 1'b1 : idle_reg;
        active_next = active_reg;
        idle_next   = idle_reg;
        shift_next  = shift_reg;
        bitcnt_next = bitcnt_reg;
        short_next  = short_reg;
        bytes_next  = bytes_reg;
        byte_valid  = 1'b0;
        byte_data   = '0;
        if (ctl.tick && active_reg)
        begin
            // End the frame once the idle count passes the limit
            if (idle_inc > cfg.timeout)
            begin
                active_next = 1'b0;
                idle_next   = '0;
            end
            else
            begin
                idle_next = idle_inc;
            end
        end
        else if (ctl.edge_ev && (ctl.rising == active_reg))
        begin
            if (is_short)
            begin
                // Two short intervals make a zero
                if (short_reg != '0)
                begin
                    short_next  = '0;
                    shift_next  = shift_reg >> 1;
                    bitcnt_next = bitcnt_reg + 1'b1;
                end
                else
                begin
                    short_next = short_reg + 1'b1;
                end
            end
            else if (is_long)
            begin
                short_next  = '0;
                shift_next  = {1'b1, shift_reg[7:1]};
                bitcnt_next = bitcnt_reg + 1'b1;
            end
            else if (!active_reg)
            begin
                // Out-of-range interval while idle starts a frame
                active_next = 1'b1;
                short_next  = '0;
                bytes_next  = '0;
                bitcnt_next = 4'd1;
                shift_next  = pwbt_pkg::RX_START_BITS;
            end
            idle_next = '0;
            if (bitcnt_next == pwbt_pkg::BYTE_BITS)
            begin
                bitcnt_next = '0;
                if (bytes_next >= cfg.skip)
                begin
                    if (cfg.enable)
                    begin
                        byte_valid = 1'b1;
                        byte_data  = shift_next;
                    end
                end
                else
                begin
                    bytes_next = bytes_next + 1'b1;
                end
                shift_next = '0;
            end
        end
    end

    // Hold receiver state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idle_reg   <= '0;
            shift_reg  <= '0;
            bitcnt_reg <= '0;
            short_reg  <= '0;
            bytes_reg  <= '0;
        end
        else
        begin
            active_reg <= active_next;
            idle_reg   <= idle_next;
            shift_reg  <= shift_next;
            bitcnt_reg <= bitcnt_next;
            short_reg  <= short_next;
            bytes_reg  <= bytes_next;
        end
    end

    assign res.active_cur = active_reg;
    assign res.active_nxt = active_next;
    assign res.byte_valid = byte_valid;
    assign res.byte_data  = byte_data;

endmodule

// File: hw/rtl/pulse_width_bit_transceiver_top.sv
// Pulse-width bit transceiver for a half-duplex single wire.
// Input stream (s_*): one command item per transfer, s_tuser holds the
// command (bit-quarter tick, captured line edge, transmit byte push) and
// s_tdata the edge polarity, edge interval and transmit byte.
// Output stream (m_*): exactly one result item for every input item, in
// order: line level and drive, a decoded receive byte with its valid flag,
// the receiving flag and the push acknowledge.
// Configuration port: cfg_we writes cfg_data into register cfg_index at
// the clock edge; write only while no item is in flight.
// Pipeline: an accepted input item is held in the input register, then its
// result goes to the result register. Throughput is one item per cycle
// unless m_tready stalls; each item updates the state in one pass of logic.
// The transmit queue is a TX_DEPTH entry memory with a registered head read.
// Reset clears all control state, loads the register defaults, releases
// the line (high, not driven) and empties the queue.
// When the receiver stalls the result item holds; one more input item is
// still taken into the input register, after which s_tready drops.
module pulse_width_bit_transceiver_top #(
    parameter int TX_DEPTH = pwbt_pkg::TX_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] edge_rising, [16:1] interval, [24:17] tx_byte
    input  logic [31:0] s_tdata,
    // [1:0] cmd
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] line_level, [1] line_drive, [2] rx_valid, [10:3] rx_byte,
    // [11] receiving, [12] push_ok
    output logic [15:0] m_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic        in_valid_reg;
    logic [1:0]  in_cmd_reg;
    logic        in_rising_reg;
    logic [15:0] in_interval_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    logic [15:0] out_data_reg;

    logic [15:0] short_min_reg;
    logic [15:0] split_point_reg;
    logic [15:0] long_max_reg;
    logic [7:0]  timeout_reg;
    logic [1:0]  skip_reg;
    logic        rx_enable_reg;
    logic        tx_enable_reg;

    logic advance;
    logic proc;
    logic accept;
    logic q_empty;
    logic q_full;
    logic [7:0] q_head;
    logic q_pop;
    logic push_ok;

    pwbt_pkg::rx_cfg_t rx_cfg;
    pwbt_pkg::rx_ctl_t rx_ctl;
    pwbt_pkg::rx_res_t rx_res;
    pwbt_pkg::tx_ctl_t tx_ctl;
    pwbt_pkg::tx_res_t tx_res;

    // Handshake: process the held item when the result register is free
    assign advance  = !out_valid_reg || m_tready;
    assign proc     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    // Hold the input item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (proc)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_cmd_reg      <= s_tuser;
            in_rising_reg   <= s_tdata[0];
            in_interval_reg <= s_tdata[16:1];
            in_byte_reg     <= s_tdata[24:17];
        end
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_min_reg   <= pwbt_pkg::SHORT_MIN_RST;
            split_point_reg <= pwbt_pkg::SPLIT_POINT_RST;
            long_max_reg    <= pwbt_pkg::LONG_MAX_RST;
            timeout_reg     <= pwbt_pkg::RX_TIMEOUT_RST;
            skip_reg        <= pwbt_pkg::SKIP_BYTES_RST;
            rx_enable_reg   <= 1'b1;
            tx_enable_reg   <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pwbt_pkg::REG_SHORT_MIN:   short_min_reg   <= cfg_data;
                pwbt_pkg::REG_SPLIT_POINT: split_point_reg <= cfg_data;
                pwbt_pkg::REG_LONG_MAX:    long_max_reg    <= cfg_data;
                pwbt_pkg::REG_RX_TIMEOUT:  timeout_reg     <= cfg_data[7:0];
                pwbt_pkg::REG_SKIP_BYTES:  skip_reg        <= cfg_data[1:0];
                pwbt_pkg::REG_RX_ENABLE:   rx_enable_reg   <= cfg_data[0];
                pwbt_pkg::REG_TX_ENABLE:   tx_enable_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Route the item to receiver and transmitter; edges are ignored while driving
    assign rx_cfg.short_min   = short_min_reg;
    assign rx_cfg.split_point = split_point_reg;
    assign rx_cfg.long_max    = long_max_reg;
    assign rx_cfg.timeout     = timeout_reg;
    assign rx_cfg.skip        = skip_reg;
    assign rx_cfg.enable      = rx_enable_reg;

    assign rx_ctl.tick     = proc && (in_cmd_reg == pwbt_pkg::CMD_TICK);
    assign rx_ctl.edge_ev  = proc && (in_cmd_reg == pwbt_pkg::CMD_EDGE) && !tx_res.drive_cur;
    assign rx_ctl.rising   = in_rising_reg;
    assign rx_ctl.interval = in_interval_reg;

    assign tx_ctl.tick    = proc && (in_cmd_reg == pwbt_pkg::CMD_TICK) && !rx_res.active_nxt;
    assign tx_ctl.q_empty = q_empty;
    assign tx_ctl.head    = q_head;

    assign push_ok = proc && (in_cmd_reg == pwbt_pkg::CMD_PUSH) && tx_enable_reg && !q_full;

    pwbt_tx_queue #(
        .DEPTH(TX_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_ok),
        .push_data (in_byte_reg),
        .pop       (q_pop),
        .empty     (q_empty),
        .full      (q_full),
        .head      (q_head)
    );

    pwbt_tx_ser u_tx (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (tx_ctl),
        .pop   (q_pop),
        .res   (tx_res)
    );

    pwbt_rx_dec u_rx (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (rx_cfg),
        .ctl   (rx_ctl),
        .res   (rx_res)
    );

    // Register the result item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            out_data_reg <= {3'b000, push_ok, rx_res.active_nxt, rx_res.byte_data,
                             rx_res.byte_valid, tx_res.drive_nxt, tx_res.level_nxt};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: hw/rtl/pwbt_checker.sv
module pwbt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // No result item right after reset
    assert property (@(posedge clk) $rose(rst_n) |-> !m_tvalid)
        else $error("result item valid right after reset");

    // A stalled result item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result item changed");

    // With no result pending the input side is free
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input not ready with empty result register");

    // An item taken during a stall fills the input stage
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready && s_tvalid && s_tready |=> !s_tready || m_tready)
        else $error("input accepted beyond pipeline capacity");

endmodule

bind pulse_width_bit_transceiver_top pwbt_checker u_pwbt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
